@@ design/dtsf_pkg.sv @@
// Shared constants and control types for the depth-tested span fill block.
`default_nettype none
package dtsf_pkg;

	// field widths
	localparam int X_W        = 16;
	localparam int Z_W        = 24;
	localparam int PIX_W      = 6;
	localparam int PDEPTH_W   = 16;
	localparam int COLOR_W    = 24;
	localparam int DIM_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// arithmetic widths: depth Q15.8 scaled by 2^16 gives Q.24 accumulator
	localparam int FRAC_SHIFT = 16;
	localparam int LEN_W      = 16;
	localparam int QUO_W      = Z_W + 1 + FRAC_SHIFT;
	localparam int INC_W      = QUO_W + 1;
	localparam int ACC_W      = 44;
	localparam int DIV_STEPS  = QUO_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam logic signed [PDEPTH_W-1:0] DEPTH_FAR = 16'sd32767;

	// defaults for top-level parameters
	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_HEIGHT_DEF = 64;
	localparam int COLOR_BITS_DEF = 24;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_TEST    = 2'd2;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 7'd64;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 7'd64;

	typedef struct packed {
		logic in_ready;
		logic load_in;
		logic prep;
		logic div_step;
		logic sign;
		logic mul;
		logic init;
		logic rd;
		logic test;
		logic clr_we;
	} dp_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic reject;
		logic len_zero;
		logic clr_done;
		logic out_free;
		logic last;
	} dp_status_t;

endpackage
`default_nettype wire

@@ design/dtsf_intf.sv @@
// Channel interfaces: span input, pixel output and configuration write.
`default_nettype none
interface dtsf_span_if;
	import dtsf_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [X_W-1:0]     x_first;
	logic signed [X_W-1:0]     x_second;
	logic signed [Z_W-1:0]     depth_first;
	logic signed [Z_W-1:0]     depth_second;
	logic signed [X_W-1:0]     row;
	logic        [COLOR_W-1:0] span_color;

	modport source (output valid, x_first, x_second, depth_first, depth_second, row,
		span_color, input ready);
	modport sink (input valid, x_first, x_second, depth_first, depth_second, row,
		span_color, output ready);
endinterface

interface dtsf_pixel_if;
	import dtsf_pkg::*;
	logic                       valid;
	logic                       ready;
	logic        [PIX_W-1:0]    pixel_x;
	logic        [PIX_W-1:0]    pixel_y;
	logic signed [PDEPTH_W-1:0] pixel_depth;
	logic        [COLOR_W-1:0]  pixel_color;
	logic                       write_pixel;
	logic                       last_of_span;

	modport source (output valid, pixel_x, pixel_y, pixel_depth, pixel_color, write_pixel,
		last_of_span, input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_depth, pixel_color, write_pixel,
		last_of_span, output ready);
endinterface

interface dtsf_cfg_if;
	import dtsf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/dtsf_ctrl.sv @@
// Sequencer: store clear, span setup, divider iterations and per-pixel steps.
`default_nettype none
module dtsf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dtsf_pkg::dp_status_t status,
	output dtsf_pkg::dp_cmd_t    cmd
);
	import dtsf_pkg::*;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_PREP,
		S_DIV,
		S_SIGN,
		S_MUL,
		S_INIT,
		S_RD,
		S_TEST
	} state_t;

	state_t                 state_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			div_cnt_q <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					if (status.clr_done) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (status.in_valid) state_q <= S_PREP;
				end
				S_PREP: begin
					div_cnt_q <= '0;
					if (status.reject) state_q <= S_IDLE;
					else if (status.len_zero) state_q <= S_SIGN;
					else state_q <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_q <= S_SIGN;
				end
				S_SIGN: state_q <= S_MUL;
				S_MUL:  state_q <= S_INIT;
				S_INIT: state_q <= S_RD;
				S_RD:   state_q <= S_TEST;
				S_TEST: begin
					// hold until the output register can take the pixel
					if (status.out_free) state_q <= status.last ? S_IDLE : S_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.in_ready = (state_q == S_IDLE);
		cmd.load_in  = (state_q == S_IDLE) && status.in_valid;
		cmd.prep     = (state_q == S_PREP);
		cmd.div_step = (state_q == S_DIV);
		cmd.sign     = (state_q == S_SIGN);
		cmd.mul      = (state_q == S_MUL);
		cmd.init     = (state_q == S_INIT);
		cmd.rd       = (state_q == S_RD);
		cmd.test     = (state_q == S_TEST);
		cmd.clr_we   = (state_q == S_CLR);
	end

endmodule
`default_nettype wire

@@ design/dtsf_datapath.sv @@
// Datapath: config registers, span setup, divider, depth stepping, depth store.
`default_nettype none
module dtsf_datapath #(
	parameter int MAX_WIDTH  = dtsf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = dtsf_pkg::MAX_HEIGHT_DEF,
	parameter int COLOR_BITS = dtsf_pkg::COLOR_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dtsf_pkg::dp_cmd_t    cmd,
	output dtsf_pkg::dp_status_t status,
	dtsf_span_if.sink            span,
	dtsf_pixel_if.source         pixel,
	dtsf_cfg_if.sink             cfg
);
	import dtsf_pkg::*;

	localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
	localparam int ROWB_W     = 2 * DIM_W;
	localparam logic [DIM_W-1:0] W_LIM = (MAX_WIDTH > 127) ? 7'd127 : 7'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] H_LIM = (MAX_HEIGHT > 127) ? 7'd127 : 7'(MAX_HEIGHT);
	localparam logic [COLOR_W-1:0] COLOR_MASK = (COLOR_BITS >= COLOR_W) ? {COLOR_W{1'b1}} :
		COLOR_W'((64'd1 << COLOR_BITS) - 64'd1);

	function automatic logic signed [PDEPTH_W-1:0] round_depth(
		input logic signed [ACC_W-1:0] a
	);
		logic [ACC_W-1:0]    mag;
		logic [ACC_W-1:0]    sum;
		logic [ACC_W-25:0]   r;
		logic [PDEPTH_W-1:0] res;
		mag = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
		sum = mag + {{(ACC_W-24){1'b0}}, 1'b1, 23'd0};
		r   = sum[ACC_W-1:24];
		// halves round away from zero, then clamp to 16 bits
		if (!a[ACC_W-1]) begin
			res = (r > (ACC_W-24)'(32767)) ? 16'h7fff : r[PDEPTH_W-1:0];
		end else begin
			res = (r > (ACC_W-24)'(32768)) ? 16'h8000 : (16'd0 - r[PDEPTH_W-1:0]);
		end
		return signed'(res);
	endfunction

	// configuration
	logic [DIM_W-1:0] w_cfg_q, h_cfg_q;
	logic             zen_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_cfg_q <= WIDTH_RESET;
			h_cfg_q <= HEIGHT_RESET;
			zen_q   <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SCREEN_WIDTH:  w_cfg_q <= cfg.data[DIM_W-1:0];
				CFG_SCREEN_HEIGHT: h_cfg_q <= cfg.data[DIM_W-1:0];
				CFG_DEPTH_TEST:    zen_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	logic [DIM_W-1:0] w_eff, h_eff;
	assign w_eff = (w_cfg_q == '0) ? 7'd1 : ((w_cfg_q > W_LIM) ? W_LIM : w_cfg_q);
	assign h_eff = (h_cfg_q == '0) ? 7'd1 : ((h_cfg_q > H_LIM) ? H_LIM : h_cfg_q);

	// captured span
	logic signed [X_W-1:0]     xa_q, xb_q, y_q;
	logic signed [Z_W-1:0]     za_q, zb_q;
	logic        [COLOR_W-1:0] color_q;

	assign span.ready = cmd.in_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			xa_q    <= span.x_first;
			xb_q    <= span.x_second;
			za_q    <= span.depth_first;
			zb_q    <= span.depth_second;
			y_q     <= span.row;
			color_q <= span.span_color & COLOR_MASK;
		end
	end

	// setup: order the ends, reject, clip
	logic                      swap;
	logic signed [X_W-1:0]     xl, xr, w_s, h_s;
	logic signed [Z_W-1:0]     zl, zr;
	logic signed [X_W:0]       len_full, neg_xl;
	logic signed [Z_W:0]       dz;
	logic        [Z_W:0]       dz_mag;
	logic                      reject_c;
	logic        [LEN_W-1:0]   len_c, clip_c;
	logic        [DIM_W-1:0]   sx_c, ex_c;
	logic        [ROWB_W-1:0]  rowbase_c;

	always_comb begin
		swap      = xa_q > xb_q;
		xl        = swap ? xb_q : xa_q;
		xr        = swap ? xa_q : xb_q;
		zl        = swap ? zb_q : za_q;
		zr        = swap ? za_q : zb_q;
		w_s       = signed'({{(X_W-DIM_W){1'b0}}, w_eff});
		h_s       = signed'({{(X_W-DIM_W){1'b0}}, h_eff});
		reject_c  = (y_q < 0) || (y_q >= h_s) || (xr < 0) || (xl >= w_s);
		len_full  = $signed({xr[X_W-1], xr}) - $signed({xl[X_W-1], xl});
		len_c     = len_full[LEN_W-1:0];
		neg_xl    = -$signed({xl[X_W-1], xl});
		clip_c    = (xl < 0) ? neg_xl[LEN_W-1:0] : '0;
		sx_c      = (xl < 0) ? '0 : xl[DIM_W-1:0];
		ex_c      = (xr >= w_s) ? (w_eff - 1'b1) : xr[DIM_W-1:0];
		dz        = $signed({zr[Z_W-1], zr}) - $signed({zl[Z_W-1], zl});
		dz_mag    = dz[Z_W] ? (Z_W+1)'(-dz) : (Z_W+1)'(dz);
		rowbase_c = {{DIM_W{1'b0}}, y_q[DIM_W-1:0]} * {{DIM_W{1'b0}}, w_eff};
	end

	assign status.in_valid = span.valid;
	assign status.reject   = reject_c;
	assign status.len_zero = (len_c == '0);

	// span working registers
	logic        [LEN_W-1:0]  len_q, clip_q, rem_q;
	logic        [QUO_W-1:0]  dvd_q, quo_q;
	logic                     neg_q;
	logic signed [INC_W-1:0]  inc_q;
	logic signed [ACC_W-1:0]  base_q, prod_q, acc_q;
	logic        [DIM_W-1:0]  x_q, ex_q;
	logic        [ROWB_W-1:0] rowbase_q;
	logic signed [PDEPTH_W-1:0] d_q, rdata_q;

	// restoring divider, one quotient bit per step
	logic [LEN_W:0]   div_t;
	logic             div_ge;
	logic [LEN_W-1:0] rem_n;
	always_comb begin
		div_t  = {rem_q, dvd_q[QUO_W-1]};
		div_ge = div_t >= {1'b0, len_q};
		rem_n  = div_ge ? LEN_W'(div_t - {1'b0, len_q}) : div_t[LEN_W-1:0];
	end

	logic signed [INC_W-1:0]     quo_s;
	logic signed [LEN_W+INC_W:0] prod_full;
	assign quo_s     = $signed({1'b0, quo_q});
	assign prod_full = (LEN_W+INC_W+1)'($signed({1'b0, clip_q})) * (LEN_W+INC_W+1)'(inc_q);

	// store access
	logic                         pass;
	logic                         out_free;
	logic                         mem_we;
	logic        [ADDR_W-1:0]     mem_addr, clr_addr_q;
	logic        [ROWB_W-1:0]     pix_addr;
	logic signed [PDEPTH_W-1:0]   mem_wdata;
	logic signed [PDEPTH_W-1:0]   mem [STORE_SIZE];
	logic                         out_valid_q;

	assign out_free  = !out_valid_q || pixel.ready;
	assign pass      = !zen_q || (rdata_q > d_q);
	assign pix_addr  = rowbase_q + {{DIM_W{1'b0}}, x_q};
	assign mem_we    = cmd.clr_we || (cmd.test && out_free && zen_q && (rdata_q > d_q));
	assign mem_addr  = cmd.clr_we ? clr_addr_q : ADDR_W'(pix_addr);
	assign mem_wdata = cmd.clr_we ? DEPTH_FAR : d_q;

	assign status.clr_done = (clr_addr_q == ADDR_W'(STORE_SIZE - 1));
	assign status.out_free = out_free;
	assign status.last     = (x_q == ex_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_we) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		if (cmd.rd) rdata_q <= mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			len_q     <= len_c;
			clip_q    <= clip_c;
			neg_q     <= dz[Z_W];
			dvd_q     <= {dz_mag, {FRAC_SHIFT{1'b0}}};
			quo_q     <= '0;
			rem_q     <= '0;
			base_q    <= {{(ACC_W-Z_W-FRAC_SHIFT){zl[Z_W-1]}}, zl, {FRAC_SHIFT{1'b0}}};
			x_q       <= sx_c;
			ex_q      <= ex_c;
			rowbase_q <= rowbase_c;
		end
		if (cmd.div_step) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[QUO_W-2:0], div_ge};
			dvd_q <= {dvd_q[QUO_W-2:0], 1'b0};
		end
		if (cmd.sign) inc_q <= neg_q ? -quo_s : quo_s;
		// left clip skips the accumulator ahead by the clipped count
		if (cmd.mul) prod_q <= prod_full[ACC_W-1:0];
		if (cmd.init) acc_q <= base_q + prod_q;
		if (cmd.rd) d_q <= round_depth(acc_q);
		if (cmd.test && out_free) begin
			acc_q <= acc_q + ACC_W'(inc_q);
			x_q   <= x_q + 1'b1;
		end
	end

	// output register
	logic        [PIX_W-1:0]    px_q, py_q;
	logic signed [PDEPTH_W-1:0] pd_q;
	logic        [COLOR_W-1:0]  pc_q;
	logic                       pw_q, pl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.test && out_free) begin
			out_valid_q <= 1'b1;
		end else if (pixel.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.test && out_free) begin
			px_q <= x_q[PIX_W-1:0];
			py_q <= y_q[PIX_W-1:0];
			pd_q <= d_q;
			pc_q <= color_q;
			pw_q <= pass;
			pl_q <= (x_q == ex_q);
		end
	end

	assign pixel.valid        = out_valid_q;
	assign pixel.pixel_x      = px_q;
	assign pixel.pixel_y      = py_q;
	assign pixel.pixel_depth  = pd_q;
	assign pixel.pixel_color  = pc_q;
	assign pixel.write_pixel  = pw_q;
	assign pixel.last_of_span = pl_q;

endmodule
`default_nettype wire

@@ design/depth_tested_span_fill_core.sv @@
// Top level of the depth-tested span fill block.
// Takes one span item at a time and emits one pixel item per visited column, left to right.
// After reset the depth store (MAX_WIDTH*MAX_HEIGHT entries) is cleared to the farthest
// depth, one entry per cycle, and no span is taken until the clear is done; configuration
// writes are taken at any time. A span passes through a setup state (a rejected span ends
// there), the one-bit-per-cycle restoring divider for the depth increment (skipped when
// both ends share a column), sign, multiply and init states that form the increment and
// the left-clip start depth, then a read state and a test state per pixel, since each pixel
// reads and then conditionally writes the single-port depth store. The test state holds
// while the pixel channel stalls. The next span can be accepted in the cycle after the
// last pixel enters the output register.
`default_nettype none
module depth_tested_span_fill_core #(
	parameter int MAX_WIDTH  = dtsf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = dtsf_pkg::MAX_HEIGHT_DEF,
	parameter int COLOR_BITS = dtsf_pkg::COLOR_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	dtsf_span_if.sink    span,
	dtsf_pixel_if.source pixel,
	dtsf_cfg_if.sink     cfg
);
	import dtsf_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	dtsf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	dtsf_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.COLOR_BITS (COLOR_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status),
		.span   (span),
		.pixel  (pixel),
		.cfg    (cfg)
	);

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for depth_tested_span_fill_core: span stimulus, pixel prediction and checking.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dtsf_pkg::*;

	localparam int STORE_ENTRIES = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
	localparam int SETTLE_CYCLES = 250;
	localparam int HOLD_OFF_CYCLES = 1500;

	typedef struct {
		logic signed [X_W-1:0] x_first;
		logic signed [X_W-1:0] x_second;
		logic signed [Z_W-1:0] depth_first;
		logic signed [Z_W-1:0] depth_second;
		logic signed [X_W-1:0] row;
		logic [COLOR_W-1:0]    span_color;
	} span_t;

	typedef struct {
		logic [PIX_W-1:0]           x;
		logic [PIX_W-1:0]           y;
		logic signed [PDEPTH_W-1:0] depth;
		logic [COLOR_W-1:0]         color;
		logic                       wr;
		logic                       last;
	} pixel_t;

	class pixel_scoreboard;
		logic signed [PDEPTH_W-1:0] zbuf[STORE_ENTRIES];
		int unsigned width_reg;
		int unsigned height_reg;
		bit          ztest_on;
		pixel_t      pending_pixels[$];
		int          errors;

		function new();
			foreach (zbuf[i])
				zbuf[i] = DEPTH_FAR;
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			ztest_on = 1'b1;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_SCREEN_WIDTH: width_reg = data;
				CFG_SCREEN_HEIGHT: height_reg = data;
				CFG_DEPTH_TEST: ztest_on = data[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return pending_pixels.size();
		endfunction

		// Q.24 accumulator to integer depth, halves away from zero, saturated
		function int round_depth(longint acc);
			longint r;
			if (acc >= 0)
				r = (acc + 8388608) / 16777216;
			else
				r = -((-acc + 8388608) / 16777216);
			if (r > 32767)
				r = 32767;
			if (r < -32768)
				r = -32768;
			return int'(r);
		endfunction

		function int clamp_dim(int unsigned v, int unsigned maxv);
			if (v < 1)
				return 1;
			if (v > maxv)
				return maxv;
			return v;
		endfunction

		// rasterize one accepted span into the queue of expected pixels
		function void take_span(span_t s);
			longint xl, xr, zl, zr, t, y, w, h, len, inc, acc, sx, ex, x;
			int     d, idx;
			pixel_t p;
			w = longint'(clamp_dim(width_reg, MAX_WIDTH_DEF));
			h = longint'(clamp_dim(height_reg, MAX_HEIGHT_DEF));
			y = longint'(s.row);
			if (y < 0 || y >= h)
				return;
			xl = longint'(s.x_first);
			xr = longint'(s.x_second);
			zl = longint'(s.depth_first);
			zr = longint'(s.depth_second);
			if (xl > xr) begin
				t = xl; xl = xr; xr = t;
				t = zl; zl = zr; zr = t;
			end
			if (xr < 0 || xl >= w)
				return;
			len = xr - xl;
			inc = (len != 0) ? ((zr - zl) * 65536) / len : 0;
			acc = zl * 65536;
			sx = xl;
			ex = xr;
			if (sx < 0) begin
				acc += (-sx) * inc;
				sx = 0;
			end
			if (ex >= w)
				ex = w - 1;
			for (x = sx; x <= ex; x++) begin
				d = round_depth(acc);
				idx = int'(y * w + x);
				p.wr = 1'b1;
				if (ztest_on && idx < STORE_ENTRIES) begin
					if (int'(zbuf[idx]) > d)
						zbuf[idx] = d[PDEPTH_W-1:0];
					else
						p.wr = 1'b0;
				end
				p.x = x[PIX_W-1:0];
				p.y = y[PIX_W-1:0];
				p.depth = d[PDEPTH_W-1:0];
				p.color = s.span_color;
				p.last = (x == ex);
				pending_pixels.push_back(p);
				acc += inc;
			end
		endfunction

		function void report(string field, logic signed [31:0] e, logic signed [31:0] g);
			$display("%0t mismatch %s: expected %0d actual %0d", $time, field, e, g);
			errors++;
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t e;
			if (pending_pixels.size() == 0) begin
				$display("%0t unexpected pixel: expected none actual x=%0d y=%0d depth=%0d",
					$time, got.x, got.y, got.depth);
				errors++;
				return;
			end
			e = pending_pixels.pop_front();
			if (got.x !== e.x)
				report("pixel_x", e.x, got.x);
			if (got.y !== e.y)
				report("pixel_y", e.y, got.y);
			if (got.depth !== e.depth)
				report("pixel_depth", e.depth, got.depth);
			if (got.color !== e.color)
				report("pixel_color", e.color, got.color);
			if (got.wr !== e.wr)
				report("write_pixel", e.wr, got.wr);
			if (got.last !== e.last)
				report("last_of_span", e.last, got.last);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	dtsf_span_if  span_ch ();
	dtsf_pixel_if pix_ch ();
	dtsf_cfg_if   cfg_ch ();

	depth_tested_span_fill_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.span  (span_ch),
		.pixel (pix_ch),
		.cfg   (cfg_ch)
	);

	pixel_scoreboard sb = new();

	bit src_idle_on;
	bit sink_idle_on;
	bit hold_off_req;
	bit hold_off_done;

	initial begin
		clk = 1'b0;
	end
	always #1 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	always @(posedge clk) begin
		span_t  s;
		pixel_t p;
		if (span_ch.valid && span_ch.ready) begin
			s.x_first = span_ch.x_first;
			s.x_second = span_ch.x_second;
			s.depth_first = span_ch.depth_first;
			s.depth_second = span_ch.depth_second;
			s.row = span_ch.row;
			s.span_color = span_ch.span_color;
			sb.take_span(s);
		end
		if (pix_ch.valid && pix_ch.ready) begin
			p.x = pix_ch.pixel_x;
			p.y = pix_ch.pixel_y;
			p.depth = pix_ch.pixel_depth;
			p.color = pix_ch.pixel_color;
			p.wr = pix_ch.write_pixel;
			p.last = pix_ch.last_of_span;
			sb.check_pixel(p);
		end
		if (cfg_ch.valid && cfg_ch.ready)
			sb.set_reg(cfg_ch.index, cfg_ch.data);
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// pixel receiver; the one long hold-off is counted here
	initial begin
		pix_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_off_done) begin
				hold_off_done = 1'b1;
				pix_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (!sink_idle_on || $urandom_range(0, 99) < 70) begin
				pix_ch.ready <= 1'b1;
				repeat ($urandom_range(0, 7)) @(posedge clk);
			end else begin
				pix_ch.ready <= 1'b0;
				repeat (pick_gap() - 1) @(posedge clk);
			end
		end
	end

	function automatic int eff_dim(int v);
		if (v < 1)
			return 1;
		if (v > 64)
			return 64;
		return v;
	endfunction

	function automatic int rand_depth();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		// a few coarse levels so spans overlap in depth and the test both passes and fails
		return ($urandom_range(0, 15) * 512 - 4096) + $urandom_range(0, 255);
	endfunction

	function automatic span_t make_span(int w, int h);
		span_t s;
		int    r, xa, xb, y, t;
		r = $urandom_range(0, 99);
		s.span_color = COLOR_W'($urandom);
		if (r < 10) begin
			s.x_first = X_W'($urandom);
			s.x_second = X_W'($urandom);
			s.depth_first = Z_W'($urandom);
			s.depth_second = Z_W'($urandom);
			s.row = X_W'($urandom);
			return s;
		end
		y = $urandom_range(0, h - 1);
		xa = $urandom_range(0, w + 15) - 8;
		xb = xa + (($urandom_range(0, 99) < 85) ? $urandom_range(0, 10) : $urandom_range(0, 80));
		if (r >= 85) begin
			case ($urandom_range(0, 3))
				0: y = -1 - $urandom_range(0, 100);
				1: y = h + $urandom_range(0, 100);
				2: begin
					xa = -1 - $urandom_range(0, 60);
					xb = xa - $urandom_range(0, 40);
				end
				default: begin
					xa = w + $urandom_range(0, 60);
					xb = xa + $urandom_range(0, 40);
				end
			endcase
		end
		if ($urandom_range(0, 1)) begin
			t = xa; xa = xb; xb = t;
		end
		s.x_first = X_W'(xa);
		s.x_second = X_W'(xb);
		s.depth_first = Z_W'(rand_depth());
		s.depth_second = Z_W'(rand_depth());
		s.row = X_W'(y);
		return s;
	endfunction

	task automatic send_span(span_t s, int gap);
		span_ch.valid <= 1'b1;
		span_ch.x_first <= s.x_first;
		span_ch.x_second <= s.x_second;
		span_ch.depth_first <= s.depth_first;
		span_ch.depth_second <= s.depth_second;
		span_ch.row <= s.row;
		span_ch.span_color <= s.span_color;
		do @(posedge clk); while (!span_ch.ready);
		if (gap > 0) begin
			span_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_fields(int xa, int xb, int za, int zb, int y, int color);
		span_t s;
		s.x_first = X_W'(xa);
		s.x_second = X_W'(xb);
		s.depth_first = Z_W'(za);
		s.depth_second = Z_W'(zb);
		s.row = X_W'(y);
		s.span_color = COLOR_W'(color);
		send_span(s, ($urandom_range(0, 2) == 0) ? pick_gap() : 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// block is idle once every pixel is back and a rejected span has had time to retire;
	// the first edge lets the monitor record a span accepted in this same time step
	task automatic settle();
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(logic [CFG_DATA_W-1:0] w_reg, logic [CFG_DATA_W-1:0] h_reg,
			bit ztest, int n, bit src_idle, bit sink_idle, bit squeeze);
		logic [CFG_DATA_W-1:0] zt_word;
		int                    i, gap;
		zt_word = CFG_DATA_W'($urandom);
		zt_word[0] = ztest;
		settle();
		write_reg(CFG_SCREEN_WIDTH, w_reg);
		write_reg(CFG_SCREEN_HEIGHT, h_reg);
		write_reg(CFG_DEPTH_TEST, zt_word);
		src_idle_on = src_idle;
		sink_idle_on = sink_idle;
		if (squeeze)
			hold_off_req = 1'b1;
		for (i = 0; i < n; i++) begin
			gap = (src_idle_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
			send_span(make_span(eff_dim(w_reg), eff_dim(h_reg)), gap);
		end
		span_ch.valid <= 1'b0;
	endtask

	initial begin
		span_ch.valid = 1'b0;
		span_ch.x_first = '0;
		span_ch.x_second = '0;
		span_ch.depth_first = '0;
		span_ch.depth_second = '0;
		span_ch.row = '0;
		span_ch.span_color = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_SCREEN_WIDTH;
		cfg_ch.data = '0;
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		hold_off_req = 1'b0;
		hold_off_done = 1'b0;
		do @(posedge clk); while (!arst_n);

		// directed spans at the reset settings (64 x 64, test on)
		send_fields(2, 10, 100 * 256, 200 * 256, 3, 24'h123456);
		send_fields(10, 2, 50 * 256, 60 * 256, 3, 24'h654321);     // ends reversed, nearer
		send_fields(2, 10, 100 * 256, 200 * 256, 3, 24'h0F0F0F);   // farther: test fails
		send_fields(5, 5, 7 * 256, 9 * 256, 0, 24'h000000);        // single pixel
		send_fields(5, 5, 7 * 256, 9 * 256, 0, 24'hFFFFFF);        // equal depth: not written
		send_fields(63, 63, 24'h000180, 0, 63, 24'hFFFFFF);       // +1.5 rounds to 2
		send_fields(0, 0, -384, 0, 1, 24'h00FF00);                 // -1.5 rounds to -2
		send_fields(0, 20, 0, 0, -1, 24'h111111);                  // rows off screen
		send_fields(0, 20, 0, 0, 64, 24'h222222);
		send_fields(0, 20, 0, 0, -32768, 24'h333333);
		send_fields(0, 20, 0, 0, 32767, 24'h444444);
		send_fields(-20, -1, 0, 0, 5, 24'h555555);                 // wholly left
		send_fields(64, 100, 0, 0, 5, 24'h666666);                 // wholly right
		send_fields(32767, 64, 0, 0, 5, 24'h777777);
		send_fields(-32768, 20, -8388608, 8388607, 10, 24'h888888); // deep left clip
		send_fields(40, 32767, 8388607, -8388608, 11, 24'h999999);  // right clip
		send_fields(-32768, 32767, 8388607, 8388607, 12, 24'hAAAAAA); // saturates high
		send_fields(32767, -32768, -8388608, -8388608, 13, 24'h555555); // saturates low
		send_fields(0, 63, 1000 * 256, -1000 * 256, 20, 24'hA5A5A5); // exact full row
		send_fields(3, 4, -8388608, 8388607, 30, 24'h5A5A5A);        // steepest step
		span_ch.valid <= 1'b0;

		run_phase(7'd64, 7'd64, 1'b1, 35, 1'b1, 1'b1, 1'b0);
		run_phase(7'd1, 7'd1, 1'b1, 25, 1'b0, 1'b0, 1'b0);
		run_phase(7'd0, 7'd0, 1'b0, 15, 1'b1, 1'b1, 1'b0);
		run_phase(7'd127, 7'd127, 1'b0, 30, 1'b1, 1'b1, 1'b0);
		run_phase(7'd64, 7'd64, 1'b1, 30, 1'b0, 1'b1, 1'b1);
		run_phase(7'd37, 7'd13, 1'b1, 35, 1'b1, 1'b1, 1'b0);
		run_phase(CFG_DATA_W'($urandom_range(1, 64)), CFG_DATA_W'($urandom_range(1, 64)),
			1'($urandom_range(0, 1)), 35, 1'b1, 1'b1, 1'b0);

		settle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ files.f @@
design/dtsf_pkg.sv
design/dtsf_intf.sv
design/dtsf_ctrl.sv
design/dtsf_datapath.sv
design/depth_tested_span_fill_core.sv
tb/testbench.sv
